### src/ffpa_pkg.sv
package ffpa_pkg;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOFIT    = 2'd1,
        ST_NOTFOUND = 2'd2,
        ST_FULL     = 2'd3
    } status_t;

    localparam logic KIND_ALLOC   = 1'b0;
    localparam logic KIND_RELEASE = 1'b1;

    localparam logic REG_TOTAL_SIZE  = 1'b0;
    localparam logic REG_OS_RESERVED = 1'b1;
    localparam int   CFG_IDX_W       = 1;

    localparam logic [15:0] RESET_TOTAL_SIZE  = 16'd512;
    localparam logic [15:0] RESET_OS_RESERVED = 16'd8;

    typedef struct packed {
        logic        kind;
        logic [15:0] request_length;
        logic [15:0] job_id;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] base_address;
        logic [15:0] part_size;
    } rsp_t;

    // One table row as stored in the partition memory.
    typedef struct packed {
        logic        used;
        logic [15:0] owner;
        logic [15:0] base;
        logic [15:0] length;
    } entry_t;

endpackage

### src/first_fit_partition_allocator_core.sv
// First-fit variable-partition allocator. The table lives in a memory with one
// write port and one registered read port, and a small sequencer walks it one
// entry at a time. Each visited entry is read, then checked. A split moves every
// entry behind the hit up one place. A release merges with free neighbors and
// then moves the entries behind it down. The block is not ready while a request
// is in work or while its result waits.
// Only entries below the live count are ever used, so the table needs no clear;
// a configuration write just reloads entry 0 and the count.
module first_fit_partition_allocator_core #(
    parameter int MAX_PARTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ffpa_pkg::req_t     in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output ffpa_pkg::rsp_t     out_data,
    input  logic               cfg_we,
    input  logic [ffpa_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [15:0]        cfg_wdata
);

    localparam int AW = $clog2(MAX_PARTS);
    localparam int CW = $clog2(MAX_PARTS + 1);
    localparam logic [CW-1:0] MAXC = CW'(MAX_PARTS);
    localparam logic [CW-1:0] ONE  = CW'(1);

    typedef enum logic [3:0] {
        S_IDLE, S_INIT, S_RD, S_CHK, S_SPL_RD, S_SPL_WR, S_SPL_FIN, S_WB,
        S_NXT_RD, S_NXT_CHK, S_PRV_RD, S_PRV_CHK, S_DEL_RD, S_DEL_WR, S_DONE
    } state_t;

    state_t            state_reg;
    logic [15:0]       total_reg, osr_reg;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     idx_reg;     // row that is written back at the end
    logic [CW-1:0]     ptr_reg;     // scan and shift pointer
    logic [CW-1:0]     shamt_reg;   // rows removed by a release merge
    logic              nxt_reg;     // the next row was merged
    ffpa_pkg::req_t    req_reg;
    ffpa_pkg::entry_t  cur_reg;     // found entry, possibly merged
    ffpa_pkg::entry_t  spl_reg;     // surplus row of a split
    ffpa_pkg::rsp_t    rsp_reg;
    logic              busy_reg;

    logic              we;
    logic [AW-1:0]     waddr, raddr;
    ffpa_pkg::entry_t  wdata, rdata;

    ffpa_table #(.DEPTH(MAX_PARTS), .AW(AW)) u_table (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    assign in_ready  = (state_reg == S_IDLE) && !busy_reg && !cfg_we;
    assign out_valid = busy_reg;
    assign out_data  = rsp_reg;

    // Memory port control.
    always_comb
    begin
        we    = 1'b0;
        waddr = idx_reg[AW-1:0];
        wdata = cur_reg;
        raddr = ptr_reg[AW-1:0];
        unique case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                waddr = '0;
                wdata = '{used: 1'b0, owner: 16'd0, base: osr_reg,
                          length: total_reg - osr_reg};
            end
            S_SPL_RD:
            begin
                raddr = AW'(ptr_reg - ONE);
            end
            S_SPL_WR:
            begin
                we    = 1'b1;
                waddr = ptr_reg[AW-1:0];
                wdata = rdata;
            end
            S_SPL_FIN:
            begin
                we    = 1'b1;
                waddr = AW'(idx_reg + ONE);
                wdata = spl_reg;
            end
            S_WB:
            begin
                we = 1'b1;
            end
            S_NXT_RD:
            begin
                raddr = AW'(idx_reg + ONE);
            end
            S_PRV_RD:
            begin
                raddr = AW'(idx_reg - ONE);
            end
            S_DEL_WR:
            begin
                we    = 1'b1;
                waddr = AW'(ptr_reg - shamt_reg);
                wdata = rdata;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            total_reg <= ffpa_pkg::RESET_TOTAL_SIZE;
            osr_reg   <= ffpa_pkg::RESET_OS_RESERVED;
            count_reg <= '0;
            idx_reg   <= '0;
            ptr_reg   <= '0;
            shamt_reg <= '0;
            nxt_reg   <= 1'b0;
            req_reg   <= '0;
            cur_reg   <= '0;
            spl_reg   <= '0;
            rsp_reg   <= '0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            if (busy_reg && out_ready)
            begin
                busy_reg <= 1'b0;
            end
            if (cfg_we && (state_reg == S_IDLE || state_reg == S_INIT))
            begin
                // A write during the reload simply restarts it.
                if (cfg_index == ffpa_pkg::REG_TOTAL_SIZE)
                begin
                    total_reg <= cfg_wdata;
                    state_reg <= S_INIT;
                end
                else if (cfg_index == ffpa_pkg::REG_OS_RESERVED)
                begin
                    osr_reg   <= cfg_wdata;
                    state_reg <= S_INIT;
                end
            end
            else
            begin
                unique case (state_reg)
                    S_IDLE:
                    begin
                        if (in_valid && in_ready)
                        begin
                            req_reg   <= in_data;
                            ptr_reg   <= '0;
                            shamt_reg <= '0;
                            nxt_reg   <= 1'b0;
                            rsp_reg   <= '{status: (in_data.kind == ffpa_pkg::KIND_RELEASE)
                                                   ? ffpa_pkg::ST_NOTFOUND
                                                   : ffpa_pkg::ST_NOFIT,
                                           base_address: 16'd0, part_size: 16'd0};
                            if (in_data.kind == ffpa_pkg::KIND_ALLOC
                                && in_data.request_length == 16'd0)
                            begin
                                state_reg <= S_DONE;
                            end
                            else
                            begin
                                state_reg <= S_RD;
                            end
                        end
                    end
                    S_INIT:
                    begin
                        count_reg <= (total_reg > osr_reg) ? ONE : '0;
                        state_reg <= S_IDLE;
                    end
                    S_RD:
                    begin
                        state_reg <= (ptr_reg < count_reg) ? S_CHK : S_DONE;
                    end
                    S_CHK:
                    begin
                        if (req_reg.kind == ffpa_pkg::KIND_ALLOC)
                        begin
                            if (!rdata.used && rdata.length >= req_reg.request_length)
                            begin
                                idx_reg <= ptr_reg;
                                cur_reg <= '{used: 1'b1, owner: req_reg.job_id,
                                             base: rdata.base,
                                             length: req_reg.request_length};
                                if (rdata.length == req_reg.request_length)
                                begin
                                    rsp_reg <= '{status: ffpa_pkg::ST_OK,
                                                 base_address: rdata.base,
                                                 part_size: req_reg.request_length};
                                    state_reg <= S_WB;
                                end
                                else if (count_reg >= MAXC)
                                begin
                                    rsp_reg <= '{status: ffpa_pkg::ST_FULL,
                                                 base_address: 16'd0, part_size: 16'd0};
                                    state_reg <= S_DONE;
                                end
                                else
                                begin
                                    rsp_reg <= '{status: ffpa_pkg::ST_OK,
                                                 base_address: rdata.base,
                                                 part_size: req_reg.request_length};
                                    spl_reg <= '{used: 1'b0, owner: 16'd0,
                                                 base: rdata.base + req_reg.request_length,
                                                 length: rdata.length
                                                         - req_reg.request_length};
                                    ptr_reg   <= count_reg;
                                    state_reg <= S_SPL_RD;
                                end
                            end
                            else
                            begin
                                ptr_reg   <= ptr_reg + ONE;
                                state_reg <= S_RD;
                            end
                        end
                        else
                        begin
                            if (rdata.used && rdata.owner == req_reg.job_id)
                            begin
                                idx_reg <= ptr_reg;
                                cur_reg <= '{used: 1'b0, owner: 16'd0,
                                             base: rdata.base, length: rdata.length};
                                rsp_reg <= '{status: ffpa_pkg::ST_OK,
                                             base_address: rdata.base,
                                             part_size: rdata.length};
                                state_reg <= S_NXT_RD;
                            end
                            else
                            begin
                                ptr_reg   <= ptr_reg + ONE;
                                state_reg <= S_RD;
                            end
                        end
                    end
                    S_SPL_RD:
                    begin
                        // Move entry ptr-1 up to ptr, walking down to idx+1.
                        state_reg <= (ptr_reg == idx_reg + ONE) ? S_SPL_FIN : S_SPL_WR;
                    end
                    S_SPL_WR:
                    begin
                        ptr_reg   <= ptr_reg - ONE;
                        state_reg <= S_SPL_RD;
                    end
                    S_SPL_FIN:
                    begin
                        count_reg <= count_reg + ONE;
                        state_reg <= S_WB;
                    end
                    S_WB:
                    begin
                        state_reg <= (shamt_reg != '0) ? S_DEL_RD : S_DONE;
                    end
                    S_NXT_RD:
                    begin
                        state_reg <= (idx_reg + ONE < count_reg) ? S_NXT_CHK : S_PRV_RD;
                    end
                    S_NXT_CHK:
                    begin
                        if (!rdata.used)
                        begin
                            cur_reg.length <= cur_reg.length + rdata.length;
                            nxt_reg        <= 1'b1;
                            shamt_reg      <= ONE;
                        end
                        state_reg <= S_PRV_RD;
                    end
                    S_PRV_RD:
                    begin
                        if (idx_reg != '0)
                        begin
                            state_reg <= S_PRV_CHK;
                        end
                        else
                        begin
                            ptr_reg   <= idx_reg + ONE + CW'(nxt_reg);
                            state_reg <= S_WB;
                        end
                    end
                    S_PRV_CHK:
                    begin
                        // The rows behind the merged span start here.
                        ptr_reg <= idx_reg + ONE + CW'(nxt_reg);
                        if (!rdata.used)
                        begin
                            idx_reg   <= idx_reg - ONE;
                            cur_reg   <= '{used: 1'b0, owner: 16'd0, base: rdata.base,
                                           length: rdata.length + cur_reg.length};
                            shamt_reg <= shamt_reg + ONE;
                        end
                        state_reg <= S_WB;
                    end
                    S_DEL_RD:
                    begin
                        // Copy entry ptr down by the number of removed rows.
                        if (ptr_reg < count_reg)
                        begin
                            state_reg <= S_DEL_WR;
                        end
                        else
                        begin
                            count_reg <= count_reg - shamt_reg;
                            state_reg <= S_DONE;
                        end
                    end
                    S_DEL_WR:
                    begin
                        ptr_reg   <= ptr_reg + ONE;
                        state_reg <= S_DEL_RD;
                    end
                    S_DONE:
                    begin
                        busy_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    default:
                    begin
                        state_reg <= S_IDLE;
                    end
                endcase
            end
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAXC)
        else $error("partition count exceeds table depth");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready)
        else $error("accepted a request while a result waits");

endmodule

### src/ffpa_table.sv
// Partition table memory: one write port, one registered read port.
module ffpa_table #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  ffpa_pkg::entry_t wdata,
    input  logic [AW-1:0]    raddr,
    output ffpa_pkg::entry_t rdata
);

    ffpa_pkg::entry_t mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
